// ----- hdl/capture_tachometer_with_timeout_assert.svh -----
// Assertion macros for the capture tachometer.
// Used by capture_tachometer_with_timeout.sv; needs clk and rst_n in scope.
`ifndef CAPTURE_TACHOMETER_WITH_TIMEOUT_ASSERT_SVH
`define CAPTURE_TACHOMETER_WITH_TIMEOUT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define CTT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tachometer check failed");
// Next-cycle implication, checked outside reset
`define CTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tachometer check failed");
`else
`define CTT_ASSERT_NOW(lbl, ante, cons)
`define CTT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/ctt_pkg.sv -----
// Shared widths, reset values and codes for the capture tachometer.
// No dependencies; imported by capture_tachometer_with_timeout.
`default_nettype none
package ctt_pkg;

  // Field and register widths
  localparam int CAP_W   = 16;
  localparam int MIN_W   = 16;
  localparam int PPR_W   = 8;
  localparam int SPEED_W = 26;
  localparam int TO_W    = 8;
  localparam int CFG_W   = 26;
  localparam int CIDX_W  = 2;

  // Default timer width
  localparam int TIMER_BITS_DEF = 16;

  // Register reset values
  localparam logic [MIN_W-1:0]   MIN_PERIOD_RST = MIN_W'(100);
  localparam logic [PPR_W-1:0]   PPR_RST        = PPR_W'(12);
  localparam logic [SPEED_W-1:0] CPM_RST        = SPEED_W'(60000000);
  localparam logic [TO_W-1:0]    TIMEOUT_RST    = TO_W'(10);

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_MIN_PERIOD = 2'd0,
    CFG_PPR        = 2'd1,
    CFG_CPM        = 2'd2,
    CFG_TIMEOUT    = 2'd3
  } cfg_idx_t;

  // Item commands
  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/capture_tachometer_with_timeout.sv -----
// Capture tachometer: speed from encoder capture periods with a stop timeout.
// Depends on ctt_pkg and capture_tachometer_with_timeout_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_stall): in_command selects a capture (encoder
//   edge, in_capture_value holds the latched timer) or a periodic tick.
//   Result channel (out_valid/out_stall): one transaction per input item with
//   the current speed and flags for an accepted capture or a timeout stop.
//   Config port (cfg_we/cfg_index/cfg_wdata): write while the block is idle.
// Timing:
//   One item at a time. A tick or a rejected capture goes from S_CALC
//   straight to S_DONE; an accepted capture passes through S_DIV, where
//   the restoring divider retires one quotient bit per cycle over the
//   26-bit speed. The result is loaded into the output register as the
//   sequencer leaves S_DONE for S_IDLE.
// Reset: registers return to their default values, stored capture, speed and
//   stop counter clear, and no result is pending.
// Stall: a result holds in the output register while out_stall is high; the
//   block still takes and computes the next item, then waits in its final
//   state until the output register frees up.
`default_nettype none
`include "capture_tachometer_with_timeout_assert.svh"
module capture_tachometer_with_timeout
  import ctt_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration port
  input  wire logic               cfg_we,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [CAP_W-1:0]   in_capture_value,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [SPEED_W-1:0]      out_speed_rpm,
  output logic                    out_capture_accepted,
  output logic                    out_stopped_now
);

  // Derived widths
  localparam int TW     = TIMER_BITS;
  localparam int PW     = TW + 1;
  localparam int KW     = (TW < CAP_W) ? TW : CAP_W;
  localparam int MW     = (PW > MIN_W) ? PW : MIN_W;
  localparam int DW     = PW + PPR_W;
  localparam int CW     = (DW > SPEED_W + 1) ? DW : SPEED_W + 1;
  localparam int DCNT_W = $clog2(SPEED_W);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SPEED_W - 1);

  // Configuration registers
  logic [MIN_W-1:0]   min_period_r;
  logic [PPR_W-1:0]   ppr_r;
  logic [SPEED_W-1:0] cpm_r;
  logic [TO_W-1:0]    timeout_r;

  // Block state
  logic [KW-1:0]      prev_cap_r;
  logic [SPEED_W-1:0] speed_r;
  logic [TO_W-1:0]    stop_cnt_r;

  // Sequencer and item registers
  state_t             state_r;
  cmd_t               cmd_r;
  logic [KW-1:0]      cap_r;
  logic               res_acc_r;
  logic               res_stop_r;

  // Divider registers
  logic [DW-1:0]      divisor_r;
  logic [SPEED_W-1:0] rem_r;
  logic [SPEED_W-1:0] quo_r;
  logic [DCNT_W-1:0]  div_cnt_r;

  // Output register
  logic               out_valid_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic               out_acc_r;
  logic               out_stop_r;

  // Combinational terms
  logic [TW-1:0]      diff;
  logic [PW-1:0]      period;
  logic               period_ok;
  logic [TO_W-1:0]    stop_cnt_inc;
  logic [CW-1:0]      trial;
  logic [CW-1:0]      trial_sub;
  logic               quo_bit;
  logic [SPEED_W-1:0] rem_nxt;
  logic [SPEED_W-1:0] quo_nxt;
  logic               in_accept;
  logic               out_free;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Period since the stored capture; equal values mean a full timer wrap
  always_comb begin
    diff = TW'(cap_r) - TW'(prev_cap_r);
    if (diff == '0) begin
      period = {1'b1, {TW{1'b0}}};
    end else begin
      period = {1'b0, diff};
    end
    period_ok    = (MW'(period) >= MW'(min_period_r));
    stop_cnt_inc = stop_cnt_r + TO_W'(1);
  end

  // Restoring divide step: shift in the next dividend bit, trial subtract.
  // A zero divisor keeps every trial positive, so the quotient saturates.
  always_comb begin
    trial     = CW'({rem_r, quo_r[SPEED_W-1]});
    trial_sub = trial - CW'(divisor_r);
    quo_bit   = (trial >= CW'(divisor_r));
    rem_nxt   = quo_bit ? trial_sub[SPEED_W-1:0] : trial[SPEED_W-1:0];
    quo_nxt   = {quo_r[SPEED_W-2:0], quo_bit};
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= MIN_PERIOD_RST;
      ppr_r        <= PPR_RST;
      cpm_r        <= CPM_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_PERIOD: min_period_r <= cfg_wdata[MIN_W-1:0];
        CFG_PPR:        ppr_r        <= cfg_wdata[PPR_W-1:0];
        CFG_CPM:        cpm_r        <= cfg_wdata[SPEED_W-1:0];
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata[TO_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence one item: take it, check, multiply, divide if accepted, hand off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      prev_cap_r <= '0;
      speed_r    <= '0;
      stop_cnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (cmd_r == CMD_TICK) begin
            // advance the stop counter; force zero speed on timeout
            if (stop_cnt_inc >= timeout_r) begin
              speed_r    <= '0;
              stop_cnt_r <= '0;
            end else begin
              stop_cnt_r <= stop_cnt_inc;
            end
            state_r <= S_DONE;
          end else if (period_ok) begin
            state_r <= S_DIV;
          end else begin
            // drop the glitch capture, state unchanged
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_cnt_r == DIV_LAST) begin
            speed_r    <= quo_nxt;
            prev_cap_r <= cap_r;
            stop_cnt_r <= '0;
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Item, flag and divider datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= cmd_t'(in_command);
      cap_r <= in_capture_value[KW-1:0];
    end
    if (state_r == S_CALC) begin
      res_acc_r  <= (cmd_r == CMD_CAPTURE) && period_ok;
      res_stop_r <= (cmd_r == CMD_TICK) && (stop_cnt_inc >= timeout_r);
      divisor_r  <= DW'(period) * DW'(ppr_r);
      rem_r      <= '0;
      quo_r      <= cpm_r;
      div_cnt_r  <= '0;
    end else if (state_r == S_DIV) begin
      rem_r     <= rem_nxt;
      quo_r     <= quo_nxt;
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_speed_r <= speed_r;
      out_acc_r   <= res_acc_r;
      out_stop_r  <= res_stop_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_speed_rpm        = out_speed_r;
  assign out_capture_accepted = out_acc_r;
  assign out_stopped_now      = out_stop_r;

  // Checks
  `CTT_ASSERT_NOW(a_flags_exclusive, out_valid_r, !(out_acc_r && out_stop_r))
  `CTT_ASSERT_NOW(a_stop_zero_speed, out_valid_r && out_stop_r, out_speed_r == '0)
  `CTT_ASSERT_NEXT(a_accept_to_calc, in_accept, state_r == S_CALC)
  `CTT_ASSERT_NEXT(a_div_runs_full, (state_r == S_DIV) && (div_cnt_r != DIV_LAST),
                   state_r == S_DIV)

endmodule
`default_nettype wire
